// ===== rtl/chained_hash_set_engine_macros.svh =====
// Assertion macros for the chained hash-set engine.
// Used by the port checker; no other dependencies.
`ifndef CHAINED_HASH_SET_ENGINE_MACROS_SVH
`define CHAINED_HASH_SET_ENGINE_MACROS_SVH

// Concurrent assertion on a given clock, disabled while reset is low
`define CHS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same, on the block clock and reset
`define CHS_ASSERT_CLK(lbl, prop, msg) `CHS_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/chs_pkg.sv =====
// Shared types and constants of the chained hash-set engine.
// No dependencies; used by every module of the block.
package chs_pkg;

  // Default sizing
  localparam int ChsKeyBytes      = 8;
  localparam int ChsMaxBucketBits = 10;
  localparam int ChsPoolEntries   = 1024;

  // Port widths
  localparam int KeyW     = 64;
  localparam int CfgDataW = 4;
  localparam int CfgIdxW  = 1;

  // DJB2-xor hash constants
  localparam logic [31:0] HashStart = 32'd5381;
  localparam int          HashShift = 5;

  // Register reset values
  localparam logic [CfgDataW-1:0] KeyLenReset  = 4'd8;
  localparam logic [CfgDataW-1:0] BktBitsReset = 4'd10;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_LENGTH  = 1'b0,
    CFG_BUCKET_BITS = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_QUERY  = 1'b1
  } req_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_HEAD,
    S_CMP,
    S_NEW,
    S_LINK,
    S_DONE
  } state_e;

  // Write enables from the sequencer to the table memories
  typedef struct packed {
    logic head_we;
    logic key_we;
    logic link_we;
  } mem_we_t;

endpackage

// ===== rtl/chained_hash_set_engine.sv =====
// Top level of the chained hash-set engine: sequencer, hash unit and table memories.
// Depends on chs_pkg, chs_hash, chs_store and chs_ctrl.
//
//  channel  direction  handshake                 payload
//  in       input      in_valid_i / in_ready_o   req_type_i, key_i
//  out      output     out_valid_o / out_ready_i found_o, inserted_o, pool_full_o
//  cfg      input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// A transaction runs from acceptance through the hash of key_length bytes (the saturated
// length), the bucket head read and a compare of each chain entry walked to a valid result;
// an insert that misses then writes and links a new entry, or flags an exhausted pool.
// The hash unit handles one key byte per cycle, the chain walk one entry read per cycle.
// After reset all 2**MAX_BUCKET_BITS bucket heads are swept clear
// with in_ready_o low; configuration writes are taken during the sweep.
// A stalled result sits in the output register; the next transaction is accepted meanwhile.
module chained_hash_set_engine #(
  parameter int KEY_BYTES       = chs_pkg::ChsKeyBytes,
  parameter int MAX_BUCKET_BITS = chs_pkg::ChsMaxBucketBits,
  parameter int POOL_ENTRIES    = chs_pkg::ChsPoolEntries
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         req_type_i,
  input  logic [chs_pkg::KeyW-1:0]     key_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         found_o,
  output logic                         inserted_o,
  output logic                         pool_full_o,
  input  logic                         cfg_we_i,
  input  logic [chs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [chs_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int KW  = 8 * KEY_BYTES;
  localparam int NBW = $clog2(KEY_BYTES + 1);
  localparam int IW  = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;

  logic                       hash_start;
  logic [NBW-1:0]             hash_nbytes;
  logic                       hash_done;
  logic [MAX_BUCKET_BITS-1:0] hash;
  chs_pkg::mem_we_t           mem_we;
  logic [MAX_BUCKET_BITS-1:0] head_waddr;
  logic [IW:0]                head_wdata;
  logic [MAX_BUCKET_BITS-1:0] head_raddr;
  logic [IW:0]                head_rdata;
  logic [IW-1:0]              ent_waddr;
  logic [KW-1:0]              key_wdata;
  logic [IW:0]                link_wdata;
  logic [IW-1:0]              ent_raddr;
  logic [KW-1:0]              key_rdata;
  logic [IW:0]                link_rdata;
  logic [KW-1:0]              key_used;

  // Only the low KEY_BYTES bytes are ever hashed, compared or stored
  assign key_used = key_i[KW-1:0];

  chs_ctrl #(
    .KEY_BYTES    (KEY_BYTES),
    .BUCKET_BITS  (MAX_BUCKET_BITS),
    .POOL_ENTRIES (POOL_ENTRIES)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .key_i         (key_used),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .found_o       (found_o),
    .inserted_o    (inserted_o),
    .pool_full_o   (pool_full_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .hash_start_o  (hash_start),
    .hash_nbytes_o (hash_nbytes),
    .hash_done_i   (hash_done),
    .hash_i        (hash),
    .mem_we_o      (mem_we),
    .head_waddr_o  (head_waddr),
    .head_wdata_o  (head_wdata),
    .head_raddr_o  (head_raddr),
    .head_rdata_i  (head_rdata),
    .ent_waddr_o   (ent_waddr),
    .key_wdata_o   (key_wdata),
    .link_wdata_o  (link_wdata),
    .ent_raddr_o   (ent_raddr),
    .key_rdata_i   (key_rdata),
    .link_rdata_i  (link_rdata)
  );

  chs_hash #(
    .KEY_BYTES   (KEY_BYTES),
    .BUCKET_BITS (MAX_BUCKET_BITS)
  ) u_hash (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (hash_start),
    .key_i    (key_used),
    .nbytes_i (hash_nbytes),
    .done_o   (hash_done),
    .hash_o   (hash)
  );

  chs_store #(
    .BUCKET_BITS  (MAX_BUCKET_BITS),
    .POOL_ENTRIES (POOL_ENTRIES),
    .KW           (KW)
  ) u_store (
    .clk_i        (clk_i),
    .mem_we_i     (mem_we),
    .head_waddr_i (head_waddr),
    .head_wdata_i (head_wdata),
    .head_raddr_i (head_raddr),
    .head_rdata_o (head_rdata),
    .ent_waddr_i  (ent_waddr),
    .key_wdata_i  (key_wdata),
    .link_wdata_i (link_wdata),
    .ent_raddr_i  (ent_raddr),
    .key_rdata_o  (key_rdata),
    .link_rdata_o (link_rdata)
  );

endmodule

// ===== rtl/chs_hash.sv =====
// Iterative DJB2-xor hash unit: one key byte per cycle.
// Depends on chs_pkg for the hash constants.
module chs_hash #(
  parameter int KEY_BYTES   = chs_pkg::ChsKeyBytes,
  parameter int BUCKET_BITS = chs_pkg::ChsMaxBucketBits,
  localparam int KW  = 8 * KEY_BYTES,
  localparam int NBW = $clog2(KEY_BYTES + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [KW-1:0]          key_i,
  input  logic [NBW-1:0]         nbytes_i,
  output logic                   done_o,
  output logic [BUCKET_BITS-1:0] hash_o
);

  logic [KW-1:0]          key_q, key_d;
  logic [NBW-1:0]         cnt_q, cnt_d;
  logic [BUCKET_BITS-1:0] h_q, h_d;
  logic [31:0]            h_ext;
  logic [31:0]            h_mul;
  logic [31:0]            h_nxt;

  // Only the low bucket bits of the hash matter: h*33 and xor keep them closed
  always_comb begin
    h_ext = 32'(h_q);
    h_mul = (h_ext << chs_pkg::HashShift) + h_ext;
    h_nxt = h_mul ^ {24'd0, key_q[7:0]};
    key_d = key_q;
    cnt_d = cnt_q;
    h_d   = h_q;
    if (start_i) begin
      key_d = key_i;
      cnt_d = nbytes_i;
      h_d   = chs_pkg::HashStart[BUCKET_BITS-1:0];
    end else if (cnt_q != '0) begin
      key_d = key_q >> 8;
      cnt_d = cnt_q - 1'b1;
      h_d   = h_nxt[BUCKET_BITS-1:0];
    end
  end

  // Hold the byte counter under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Advance the hash and the key shifter
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    h_q   <= h_d;
  end

  assign done_o = (cnt_q == '0);
  assign hash_o = h_q;

endmodule

// ===== rtl/chs_store.sv =====
// Table memories: bucket heads, entry keys and entry links, registered reads.
// Depends on chs_pkg for the write-enable struct.
module chs_store #(
  parameter int BUCKET_BITS  = chs_pkg::ChsMaxBucketBits,
  parameter int POOL_ENTRIES = chs_pkg::ChsPoolEntries,
  parameter int KW           = 8 * chs_pkg::ChsKeyBytes,
  localparam int IW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1
) (
  input  logic                   clk_i,
  input  chs_pkg::mem_we_t       mem_we_i,
  input  logic [BUCKET_BITS-1:0] head_waddr_i,
  input  logic [IW:0]            head_wdata_i,
  input  logic [BUCKET_BITS-1:0] head_raddr_i,
  output logic [IW:0]            head_rdata_o,
  input  logic [IW-1:0]          ent_waddr_i,
  input  logic [KW-1:0]          key_wdata_i,
  input  logic [IW:0]            link_wdata_i,
  input  logic [IW-1:0]          ent_raddr_i,
  output logic [KW-1:0]          key_rdata_o,
  output logic [IW:0]            link_rdata_o
);

  logic [IW:0]   head_mem [2**BUCKET_BITS];
  logic [KW-1:0] key_mem  [POOL_ENTRIES];
  logic [IW:0]   link_mem [POOL_ENTRIES];

  // Bucket heads: valid bit over entry index
  always_ff @(posedge clk_i) begin
    if (mem_we_i.head_we) begin
      head_mem[head_waddr_i] <= head_wdata_i;
    end
    head_rdata_o <= head_mem[head_raddr_i];
  end

  // Entry keys
  always_ff @(posedge clk_i) begin
    if (mem_we_i.key_we) begin
      key_mem[ent_waddr_i] <= key_wdata_i;
    end
    key_rdata_o <= key_mem[ent_raddr_i];
  end

  // Entry links: valid bit over next entry index
  always_ff @(posedge clk_i) begin
    if (mem_we_i.link_we) begin
      link_mem[ent_waddr_i] <= link_wdata_i;
    end
    link_rdata_o <= link_mem[ent_raddr_i];
  end

endmodule

// ===== rtl/chs_ctrl.sv =====
// Sequencer: configuration, head clearing, chain walk, insert and result register.
// Depends on chs_pkg for states, codes and the write-enable struct.
module chs_ctrl #(
  parameter int KEY_BYTES    = chs_pkg::ChsKeyBytes,
  parameter int BUCKET_BITS  = chs_pkg::ChsMaxBucketBits,
  parameter int POOL_ENTRIES = chs_pkg::ChsPoolEntries,
  localparam int KW  = 8 * KEY_BYTES,
  localparam int NBW = $clog2(KEY_BYTES + 1),
  localparam int IW  = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1,
  localparam int CW  = $clog2(POOL_ENTRIES + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           req_type_i,
  input  logic [KW-1:0]                  key_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           found_o,
  output logic                           inserted_o,
  output logic                           pool_full_o,
  input  logic                           cfg_we_i,
  input  logic [chs_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [chs_pkg::CfgDataW-1:0]   cfg_data_i,
  output logic                           hash_start_o,
  output logic [NBW-1:0]                 hash_nbytes_o,
  input  logic                           hash_done_i,
  input  logic [BUCKET_BITS-1:0]         hash_i,
  output chs_pkg::mem_we_t               mem_we_o,
  output logic [BUCKET_BITS-1:0]         head_waddr_o,
  output logic [IW:0]                    head_wdata_o,
  output logic [BUCKET_BITS-1:0]         head_raddr_o,
  input  logic [IW:0]                    head_rdata_i,
  output logic [IW-1:0]                  ent_waddr_o,
  output logic [KW-1:0]                  key_wdata_o,
  output logic [IW:0]                    link_wdata_o,
  output logic [IW-1:0]                  ent_raddr_o,
  input  logic [KW-1:0]                  key_rdata_i,
  input  logic [IW:0]                    link_rdata_i
);

  chs_pkg::state_e              state_q, state_d;
  logic [chs_pkg::CfgDataW-1:0] key_len_q, key_len_d;
  logic [chs_pkg::CfgDataW-1:0] bkt_bits_q, bkt_bits_d;
  logic [BUCKET_BITS-1:0]       clr_cnt_q, clr_cnt_d;
  logic [CW-1:0]                used_q, used_d;
  logic                         out_valid_q, out_valid_d;

  chs_pkg::req_e                req_q, req_d;
  logic [KW-1:0]                key_q, key_d;
  logic [NBW-1:0]               nb_q, nb_d;
  logic [BUCKET_BITS-1:0]       bucket_q, bucket_d;
  logic [IW-1:0]                cur_q, cur_d;
  logic                         tail_q, tail_d;
  logic                         found_q, found_d;
  logic                         ins_q, ins_d;
  logic                         full_q, full_d;
  logic                         out_found_q, out_found_d;
  logic                         out_ins_q, out_ins_d;
  logic                         out_full_q, out_full_d;

  logic [NBW-1:0]               nb_eff;
  logic [chs_pkg::CfgDataW:0]   bb_eff;
  logic [BUCKET_BITS-1:0]       bmask;
  logic [KW-1:0]                kmask;
  logic                         match;
  logic [IW-1:0]                used_idx;

  // Saturate the key length into 1..KEY_BYTES
  always_comb begin
    if (key_len_q == '0) begin
      nb_eff = NBW'(1);
    end else if (key_len_q > chs_pkg::CfgDataW'(KEY_BYTES)) begin
      nb_eff = NBW'(KEY_BYTES);
    end else begin
      nb_eff = key_len_q[NBW-1:0];
    end
  end

  // Saturate the bucket bits into 1..BUCKET_BITS and build the index mask
  always_comb begin
    if (bkt_bits_q == '0) begin
      bb_eff = (chs_pkg::CfgDataW+1)'(1);
    end else if ({1'b0, bkt_bits_q} > (chs_pkg::CfgDataW+1)'(BUCKET_BITS)) begin
      bb_eff = (chs_pkg::CfgDataW+1)'(BUCKET_BITS);
    end else begin
      bb_eff = {1'b0, bkt_bits_q};
    end
    for (int i = 0; i < BUCKET_BITS; i++) begin
      bmask[i] = (i < int'(bb_eff));
    end
  end

  // Byte mask for the key compare
  always_comb begin
    for (int b = 0; b < KEY_BYTES; b++) begin
      kmask[8*b +: 8] = {8{(b < int'(nb_q))}};
    end
  end

  assign match    = ~|((key_rdata_i ^ key_q) & kmask);
  assign used_idx = used_q[IW-1:0];

  // Configuration writes
  always_comb begin
    key_len_d  = key_len_q;
    bkt_bits_d = bkt_bits_q;
    if (cfg_we_i) begin
      unique case (chs_pkg::cfg_reg_e'(cfg_idx_i))
        chs_pkg::CFG_KEY_LENGTH:  key_len_d  = cfg_data_i;
        chs_pkg::CFG_BUCKET_BITS: bkt_bits_d = cfg_data_i;
      endcase
    end
  end

  // Next state, memory requests and result
  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    used_d       = used_q;
    req_d        = req_q;
    key_d        = key_q;
    nb_d         = nb_q;
    bucket_d     = bucket_q;
    cur_d        = cur_q;
    tail_d       = tail_q;
    found_d      = found_q;
    ins_d        = ins_q;
    full_d       = full_q;
    out_found_d  = out_found_q;
    out_ins_d    = out_ins_q;
    out_full_d   = out_full_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    hash_start_o = 1'b0;
    mem_we_o     = '0;
    head_waddr_o = bucket_q;
    head_wdata_o = {1'b1, used_idx};
    head_raddr_o = hash_i & bmask;
    ent_waddr_o  = used_idx;
    key_wdata_o  = key_q;
    link_wdata_o = '0;
    ent_raddr_o  = cur_q;

    unique case (state_q)
      // Sweep all bucket heads to invalid after reset
      chs_pkg::S_CLEAR: begin
        mem_we_o.head_we = 1'b1;
        head_waddr_o     = clr_cnt_q;
        head_wdata_o     = '0;
        clr_cnt_d        = clr_cnt_q + 1'b1;
        if (clr_cnt_q == '1) begin
          state_d = chs_pkg::S_IDLE;
        end
      end
      // Take a transaction and start the hash
      chs_pkg::S_IDLE: begin
        if (in_valid_i) begin
          req_d        = chs_pkg::req_e'(req_type_i);
          key_d        = key_i;
          nb_d         = nb_eff;
          tail_d       = 1'b0;
          found_d      = 1'b0;
          ins_d        = 1'b0;
          full_d       = 1'b0;
          hash_start_o = 1'b1;
          state_d      = chs_pkg::S_HASH;
        end
      end
      // Wait for the hash, read the bucket head
      chs_pkg::S_HASH: begin
        if (hash_done_i) begin
          bucket_d = hash_i & bmask;
          state_d  = chs_pkg::S_HEAD;
        end
      end
      // Empty bucket ends the walk, otherwise fetch the first entry
      chs_pkg::S_HEAD: begin
        if (head_rdata_i[IW]) begin
          cur_d       = head_rdata_i[IW-1:0];
          ent_raddr_o = head_rdata_i[IW-1:0];
          tail_d      = 1'b1;
          state_d     = chs_pkg::S_CMP;
        end else if (req_q == chs_pkg::REQ_INSERT) begin
          state_d = chs_pkg::S_NEW;
        end else begin
          state_d = chs_pkg::S_DONE;
        end
      end
      // Compare one entry per cycle and follow the link
      chs_pkg::S_CMP: begin
        if (match) begin
          found_d = 1'b1;
          state_d = chs_pkg::S_DONE;
        end else if (link_rdata_i[IW]) begin
          cur_d       = link_rdata_i[IW-1:0];
          ent_raddr_o = link_rdata_i[IW-1:0];
        end else if (req_q == chs_pkg::REQ_INSERT) begin
          state_d = chs_pkg::S_NEW;
        end else begin
          state_d = chs_pkg::S_DONE;
        end
      end
      // Write the new entry, or flag an exhausted pool
      chs_pkg::S_NEW: begin
        if (used_q == CW'(POOL_ENTRIES)) begin
          full_d  = 1'b1;
          state_d = chs_pkg::S_DONE;
        end else begin
          mem_we_o.key_we  = 1'b1;
          mem_we_o.link_we = 1'b1;
          state_d          = chs_pkg::S_LINK;
        end
      end
      // Hook the new entry onto the tail, or make it the head
      chs_pkg::S_LINK: begin
        if (tail_q) begin
          mem_we_o.link_we = 1'b1;
          ent_waddr_o      = cur_q;
          link_wdata_o     = {1'b1, used_idx};
        end else begin
          mem_we_o.head_we = 1'b1;
        end
        used_d  = used_q + 1'b1;
        ins_d   = 1'b1;
        state_d = chs_pkg::S_DONE;
      end
      // Load the result register once it is free
      chs_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_found_d = found_q;
          out_ins_d   = ins_q;
          out_full_d  = full_q;
          out_valid_d = 1'b1;
          state_d     = chs_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = chs_pkg::S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= chs_pkg::S_CLEAR;
      key_len_q   <= chs_pkg::KeyLenReset;
      bkt_bits_q  <= chs_pkg::BktBitsReset;
      clr_cnt_q   <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      key_len_q   <= key_len_d;
      bkt_bits_q  <= bkt_bits_d;
      clr_cnt_q   <= clr_cnt_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Per-transaction payload
  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    key_q       <= key_d;
    nb_q        <= nb_d;
    bucket_q    <= bucket_d;
    cur_q       <= cur_d;
    tail_q      <= tail_d;
    found_q     <= found_d;
    ins_q       <= ins_d;
    full_q      <= full_d;
    out_found_q <= out_found_d;
    out_ins_q   <= out_ins_d;
    out_full_q  <= out_full_d;
  end

  assign in_ready_o    = (state_q == chs_pkg::S_IDLE);
  assign hash_nbytes_o = nb_eff;
  assign out_valid_o   = out_valid_q;
  assign found_o       = out_found_q;
  assign inserted_o    = out_ins_q;
  assign pool_full_o   = out_full_q;

endmodule

// ===== rtl/chs_checker.sv =====
// Port-level checker for the chained hash-set engine, bound to the top level.
// Depends on chained_hash_set_engine_macros.svh.
`include "chained_hash_set_engine_macros.svh"

module chs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic found_o,
  input logic inserted_o,
  input logic pool_full_o
);

  // A stalled result holds
  `CHS_ASSERT_CLK(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(found_o) && $stable(inserted_o) && $stable(pool_full_o), "result changed while stalled")

  // One transaction at a time: busy right after acceptance
  `CHS_ASSERT_CLK(a_busy_after_accept, in_valid_i && in_ready_o |=> !in_ready_o, "ready right after an accepted transaction")

  // The result flags exclude each other
  `CHS_ASSERT_CLK(a_flags_exclusive, out_valid_o |-> $countones({found_o, inserted_o, pool_full_o}) <= 1, "more than one result flag set")

  // The sequencer waits in the hash state first, so no result loads right after acceptance
  `CHS_ASSERT_CLK(a_no_early_result, in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o, "result loaded in the cycle after acceptance")

endmodule

bind chained_hash_set_engine chs_checker u_chs_checker (.*);
